@@ rtl/pbps_pkg.sv @@
package pbps_pkg;

  localparam int unsigned MAX_PATHS_DEF = 256;
  localparam int unsigned ENT_W         = 16;
  localparam int unsigned PEN_W         = 4;
  localparam int unsigned LOG2_W        = 4;
  localparam int unsigned PCNT_W        = 9;
  localparam int unsigned PCNT_MAX      = 511;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [PEN_W-1:0] PEN_ECN  = 4'd1;
  localparam logic [PEN_W-1:0] PEN_NACK = 4'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PATH_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PEN   = 2'd2;

  localparam logic [LOG2_W-1:0] RST_PATH_LOG2 = 4'd8;
  localparam logic [ENT_W-1:0]  RST_UPPER     = 16'd0;
  localparam logic [PEN_W-1:0]  RST_MAX_PEN   = 4'd15;

  localparam logic REQ_FEEDBACK = 1'b0;
  localparam logic REQ_NEXT     = 1'b1;

  localparam logic [1:0] FB_GOOD    = 2'd0;
  localparam logic [1:0] FB_ECN     = 2'd1;
  localparam logic [1:0] FB_NACK    = 2'd2;
  localparam logic [1:0] FB_TIMEOUT = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic [ENT_W-1:0] path_id;
    logic [1:0]       feedback;
    logic [ENT_W-1:0] random_word;
  } in_item_t;

  typedef struct packed {
    logic [ENT_W-1:0]  entropy;
    logic [PCNT_W-1:0] penalized_count;
    logic              gave_up;
  } result_t;

  typedef struct packed {
    logic [LOG2_W-1:0] path_count_log2;
    logic [ENT_W-1:0]  upper_bits;
    logic [PEN_W-1:0]  max_penalty;
  } cfg_t;

endpackage

@@ rtl/pbps_cfg.sv @@
module pbps_cfg import pbps_pkg::*; #(
  parameter int unsigned MAX_PATHS = MAX_PATHS_DEF,
  localparam int unsigned IDX_W = $clog2(MAX_PATHS),
  localparam int unsigned CNT_W = IDX_W + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [CFG_IDX_W-1:0] index_i,
  input  logic [ENT_W-1:0]     data_i,
  output cfg_t                 cfg_o,
  output logic [CNT_W-1:0]     count_o,
  output logic [IDX_W-1:0]     mask_o
);

  cfg_t cfg_q;
  logic [16:0] pow;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.path_count_log2 <= RST_PATH_LOG2;
      cfg_q.upper_bits      <= RST_UPPER;
      cfg_q.max_penalty     <= RST_MAX_PEN;
    end else if (we_i) begin
      case (index_i)
        CFG_PATH_LOG2: cfg_q.path_count_log2 <= data_i[LOG2_W-1:0];
        CFG_UPPER:     cfg_q.upper_bits      <= data_i;
        CFG_MAX_PEN:   cfg_q.max_penalty     <= data_i[PEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pow = 17'd1 << cfg_q.path_count_log2;
    if (pow > 17'(MAX_PATHS)) begin
      cnt = CNT_W'(MAX_PATHS);
    end else if (pow < 17'd2) begin
      cnt = CNT_W'(2);
    end else begin
      cnt = pow[CNT_W-1:0];
    end
    cnt_m1 = cnt - CNT_W'(1);
  end

  assign cfg_o   = cfg_q;
  assign count_o = cnt;
  assign mask_o  = cnt_m1[IDX_W-1:0];

endmodule

@@ rtl/penalty_bitmap_path_sprayer_top.sv @@
// Path sprayer with a per-path penalty table.
// Command channel: item_i is taken at a clock edge where start is high and
// busy is low. A feedback beat adds a penalty to one path; a request beat
// returns the next entropy value, skipping penalized paths.
// Every beat gives one result on result_o, shown for one cycle with
// result_valid_o high. The receiver cannot stall; results are never held.
// Steps: a feedback beat reads its path's entry in the penalty memory, then
// checks it and writes the new penalty back; the result is registered after
// the check. A request beat makes one probe per path tried until a path is
// clear, or gives up after path count + 1 penalized probes. Each probe is
// one read of the penalty memory and one check with a possible write back.
// busy is low again in the cycle the result is shown, so a new item can be
// taken in that cycle; no new item is taken while one is in progress.
// Configuration beats on cfg_valid_i/cfg_ready_o are always taken; write
// them only while the block is idle.
// After reset the penalty memory is cleared, one entry a cycle, over all
// MAX_PATHS entries; busy stays high until the pass is done.
module penalty_bitmap_path_sprayer_top import pbps_pkg::*; #(
  parameter int unsigned MAX_PATHS = MAX_PATHS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             item_i,
  output logic                 result_valid_o,
  output result_t              result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ENT_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_PATHS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned TOT_W = IDX_W + 1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  cfg_t             cfg;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] mask;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] clr_q;
  logic [IDX_W-1:0] rot_q, rot_d;
  logic [IDX_W-1:0] scr_q, scr_d;
  logic [TOT_W-1:0] total_q, total_d;
  logic [IDX_W-1:0] addr_q, addr_d;
  logic             first_q, first_d;
  logic [CNT_W:0]   probes_q, probes_d;
  in_item_t         item_q;
  result_t          out_q, out_d;
  logic             out_vld_q, out_vld_d;

  logic [PEN_W-1:0] pen_mem [MAX_PATHS];
  logic [PEN_W-1:0] rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [PEN_W-1:0] mem_wd;

  logic             accept;
  logic [PEN_W-1:0] add;
  logic [PEN_W:0]   sum;
  logic [PEN_W-1:0] fb_val;
  logic [CNT_W-1:0] rot_inc;
  logic [IDX_W-1:0] adv_rot;
  logic [IDX_W-1:0] adv_scr;
  logic [ENT_W-1:0] ent;
  logic             upd;

  assign cfg_ready_o = 1'b1;

  pbps_cfg #(
    .MAX_PATHS(MAX_PATHS)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_valid_i & cfg_ready_o),
    .index_i(cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg),
    .count_o(count),
    .mask_o (mask)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start & ~busy;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pen_mem[mem_wa] <= mem_wd;
    end
    if (state_q == ST_READ) begin
      rdata_q <= pen_mem[addr_q];
    end
  end

  always_comb begin
    rot_inc = {1'b0, rot_q} + CNT_W'(1);
    if (rot_inc >= count) begin
      adv_rot = '0;
      adv_scr = item_q.random_word[IDX_W-1:0] & mask;
    end else begin
      adv_rot = rot_inc[IDX_W-1:0];
      adv_scr = scr_q;
    end

    case (item_q.feedback)
      FB_ECN:     add = PEN_ECN;
      FB_NACK:    add = PEN_NACK;
      FB_TIMEOUT: add = cfg.max_penalty;
      default:    add = '0;
    endcase
    sum    = {1'b0, rdata_q} + {1'b0, add};
    fb_val = (sum > {1'b0, cfg.max_penalty}) ? cfg.max_penalty : sum[PEN_W-1:0];

    ent = ENT_W'(addr_q) | (cfg.upper_bits & ~ENT_W'(mask));

    state_d   = state_q;
    rot_d     = rot_q;
    scr_d     = scr_q;
    total_d   = total_q;
    addr_d    = addr_q;
    first_d   = first_q;
    probes_d  = probes_q;
    out_d     = out_q;
    out_vld_d = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = addr_q;
    mem_wd    = '0;
    upd       = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        if (clr_q == IDX_W'(MAX_PATHS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d  = ST_READ;
          first_d  = 1'b1;
          probes_d = '0;
          if (item_i.req_type == REQ_NEXT) begin
            addr_d = (rot_q ^ scr_q) & mask;
          end else begin
            addr_d = item_i.path_id[IDX_W-1:0] & mask;
          end
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        out_d.entropy = '0;
        out_d.gave_up = 1'b0;
        if (item_q.req_type == REQ_FEEDBACK) begin
          mem_we    = 1'b1;
          mem_wd    = fb_val;
          upd       = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          rot_d = adv_rot;
          scr_d = adv_scr;
          if (rdata_q == '0) begin
            out_d.entropy = ent;
            out_vld_d     = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            if (first_q) begin
              mem_we = 1'b1;
              mem_wd = rdata_q - PEN_W'(1);
              upd    = 1'b1;
            end
            first_d  = 1'b0;
            probes_d = probes_q + (CNT_W+1)'(1);
            if (probes_d > {1'b0, count}) begin
              out_d.entropy = ent;
              out_d.gave_up = 1'b1;
              out_vld_d     = 1'b1;
              state_d       = ST_IDLE;
            end else begin
              addr_d  = (adv_rot ^ adv_scr) & mask;
              state_d = ST_READ;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (upd) begin
      if (rdata_q == '0 && mem_wd != '0) begin
        total_d = total_q + TOT_W'(1);
      end else if (rdata_q != '0 && mem_wd == '0 && total_q != '0) begin
        total_d = total_q - TOT_W'(1);
      end
    end

    if (total_d > TOT_W'(PCNT_MAX)) begin
      out_d.penalized_count = PCNT_W'(PCNT_MAX);
    end else begin
      out_d.penalized_count = PCNT_W'(total_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rot_q     <= '0;
      scr_q     <= '0;
      total_q   <= '0;
      first_q   <= 1'b0;
      probes_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_q + IDX_W'(1);
      rot_q     <= rot_d;
      scr_q     <= scr_d;
      total_q   <= total_d;
      first_q   <= first_d;
      probes_q  <= probes_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    addr_q <= addr_d;
    out_q  <= out_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

  a_result_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> state_q == ST_IDLE)
    else $error("result strobe outside idle");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOT_W'(MAX_PATHS))
    else $error("penalized total above path capacity");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> probes_q <= {1'b0, count})
    else $error("probe count past give-up limit");

  a_feedback_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && item_q.req_type == REQ_FEEDBACK |->
      out_q.entropy == '0 && !out_q.gave_up)
    else $error("feedback beat with request result");

endmodule

@@ tb/sv/spray_checker.sv @@
`timescale 1ns / 100ps

module spray_checker import pbps_pkg::*; #(
  parameter int unsigned MAX_PATHS = MAX_PATHS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  in_item_t             item_i,
  input  logic                 result_valid_i,
  input  result_t              result_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ENT_W-1:0]     cfg_data_i,
  output int                   pending_o,
  output int                   mismatches_o
);

  localparam int unsigned PICK_DEPTH = 16;

  logic [PEN_W-1:0]  path_pen [MAX_PATHS];
  int unsigned       rot_idx;
  int unsigned       scr;
  int unsigned       pen_total;
  logic [LOG2_W-1:0] log2_q;
  logic [ENT_W-1:0]  upper_q;
  logic [PEN_W-1:0]  maxpen_q;

  result_t     picks [PICK_DEPTH];
  int unsigned pick_rd;
  int unsigned pick_wr;
  result_t     want;

  initial mismatches_o = 0;
  initial pending_o = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    if (mismatches_o < 200) begin
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, exp_v);
    end
    mismatches_o++;
  endtask

  function automatic void clear_model();
    for (int i = 0; i < MAX_PATHS; i++) path_pen[i] = '0;
    rot_idx   = 0;
    scr       = 0;
    pen_total = 0;
    log2_q    = RST_PATH_LOG2;
    upper_q   = RST_UPPER;
    maxpen_q  = RST_MAX_PEN;
    pick_rd   = 0;
    pick_wr   = 0;
  endfunction

  function automatic int unsigned paths_in_use();
    int unsigned c;
    c = 1 << log2_q;
    if (c > MAX_PATHS) c = MAX_PATHS;
    if (c < 2) c = 2;
    return c;
  endfunction

  function automatic void set_pen(int unsigned idx, int unsigned v);
    if (path_pen[idx] == 0 && v != 0) begin
      pen_total++;
    end else if (path_pen[idx] != 0 && v == 0 && pen_total > 0) begin
      pen_total--;
    end
    path_pen[idx] = PEN_W'(v);
  endfunction

  function automatic void step_rotation(int unsigned count, int unsigned mask,
                                        logic [ENT_W-1:0] rnd);
    rot_idx++;
    if (rot_idx >= count) begin
      rot_idx = 0;
      scr = 32'(rnd) & mask;
    end
  endfunction

  function automatic result_t spray_next(in_item_t it);
    int unsigned count;
    int unsigned mask;
    int unsigned e;
    int unsigned v;
    int unsigned probes;
    logic        first;
    result_t     r;
    count = paths_in_use();
    mask  = count - 1;
    r     = '0;
    if (it.req_type == REQ_FEEDBACK) begin
      e = 32'(it.path_id) & mask;
      case (it.feedback)
        FB_ECN:     v = 32'(PEN_ECN);
        FB_NACK:    v = 32'(PEN_NACK);
        FB_TIMEOUT: v = 32'(maxpen_q);
        default:    v = 0;
      endcase
      v = 32'(path_pen[e]) + v;
      if (v > 32'(maxpen_q)) v = 32'(maxpen_q);
      set_pen(e, v);
    end else begin
      e      = (rot_idx ^ scr) & mask;
      first  = 1'b1;
      probes = 0;
      while (path_pen[e] != 0 && !r.gave_up) begin
        if (first) set_pen(e, 32'(path_pen[e]) - 1);
        first = 1'b0;
        probes++;
        if (probes > count) begin
          r.gave_up = 1'b1;
        end else begin
          step_rotation(count, mask, it.random_word);
          e = (rot_idx ^ scr) & mask;
        end
      end
      step_rotation(count, mask, it.random_word);
      r.entropy = ENT_W'(e | (32'(upper_q) & ~mask));
    end
    r.penalized_count = PCNT_W'((pen_total > PCNT_MAX) ? PCNT_MAX : pen_total);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_model();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PATH_LOG2: log2_q   = cfg_data_i[LOG2_W-1:0];
          CFG_UPPER:     upper_q  = cfg_data_i;
          CFG_MAX_PEN:   maxpen_q = cfg_data_i[PEN_W-1:0];
          default: ;
        endcase
      end
      if (result_valid_i) begin
        if (pick_wr == pick_rd) begin
          report_mismatch("result with none expected", 32'(result_i), '0);
        end else begin
          want = picks[pick_rd % PICK_DEPTH];
          pick_rd++;
          if (result_i.entropy !== want.entropy) begin
            report_mismatch("entropy", 32'(result_i.entropy), 32'(want.entropy));
          end
          if (result_i.penalized_count !== want.penalized_count) begin
            report_mismatch("penalized_count", 32'(result_i.penalized_count),
                            32'(want.penalized_count));
          end
          if (result_i.gave_up !== want.gave_up) begin
            report_mismatch("gave_up", 32'(result_i.gave_up), 32'(want.gave_up));
          end
        end
      end
      if (start_i && !busy_i) begin
        picks[pick_wr % PICK_DEPTH] = spray_next(item_i);
        pick_wr++;
      end
    end
    pending_o <= int'(pick_wr - pick_rd);
  end

endmodule

@@ tb/sv/penalty_bitmap_path_sprayer_top_tb.sv @@
`timescale 1ns / 100ps

module penalty_bitmap_path_sprayer_top_tb;
  import pbps_pkg::*;

  localparam int unsigned PHASES          = 12;
  localparam int unsigned BEATS_PER_PHASE = 160;
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  in_item_t             item_i;
  logic                 result_valid_o;
  result_t              result_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [ENT_W-1:0]     cfg_data_i;

  int          pending;
  int          mismatches;
  int unsigned burst_left;
  int unsigned cycles;
  logic        no_gaps;

  penalty_bitmap_path_sprayer_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  spray_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item_i),
    .result_valid_i (result_valid_o),
    .result_i       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending),
    .mismatches_o   (mismatches)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic in_item_t beat_of(logic req, logic [ENT_W-1:0] path,
                                       logic [1:0] fb, logic [ENT_W-1:0] rnd);
    in_item_t it;
    it.req_type    = req;
    it.path_id     = path;
    it.feedback    = fb;
    it.random_word = rnd;
    return it;
  endfunction

  function automatic in_item_t rand_beat(int unsigned req_pct);
    int unsigned sel;
    logic [1:0]  fb;
    sel = $urandom_range(0, 99);
    fb  = (sel < 20) ? FB_GOOD : (sel < 45) ? FB_ECN : (sel < 70) ? FB_NACK : FB_TIMEOUT;
    return beat_of(($urandom_range(0, 99) < req_pct) ? REQ_NEXT : REQ_FEEDBACK,
                   ENT_W'($urandom), fb, ENT_W'($urandom));
  endfunction

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic send_beat(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 199) == 0) drain();
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ENT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [LOG2_W-1:0] lg;
    logic [ENT_W-1:0]  up;
    logic [PEN_W-1:0]  mp;
    int unsigned       req_pct;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    burst_left  = 0;
    no_gaps     = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_beat(beat_of(REQ_FEEDBACK, 16'h0001, FB_TIMEOUT, 16'h0000));
    send_beat(beat_of(REQ_FEEDBACK, 16'hFF02, FB_NACK, 16'hFFFF));
    send_beat(beat_of(REQ_FEEDBACK, 16'h0003, FB_ECN, 16'h0000));
    send_beat(beat_of(REQ_FEEDBACK, 16'hFFFF, FB_GOOD, 16'h0000));
    send_beat(beat_of(REQ_FEEDBACK, 16'h0003, FB_ECN, 16'hFFFF));
    send_beat(beat_of(REQ_NEXT, 16'h0000, FB_GOOD, 16'hFFFF));
    send_beat(beat_of(REQ_NEXT, 16'hFFFF, FB_TIMEOUT, 16'hA5A5));
    send_beat(beat_of(REQ_FEEDBACK, 16'h0002, FB_TIMEOUT, 16'h0000));
    send_beat(beat_of(REQ_FEEDBACK, 16'h0001, FB_NACK, 16'h0000));
    send_beat(beat_of(REQ_FEEDBACK, 16'h0001, FB_GOOD, 16'h5A5A));
    send_beat(beat_of(REQ_NEXT, 16'h8000, FB_NACK, 16'h0000));

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        drain();
        repeat (4) @(negedge clk_i);
        case (p)
          1:       begin lg = 4'd1;  up = 16'hFFFF; mp = 4'd15; end
          2:       begin lg = 4'd2;  up = 16'hA5A5; mp = 4'd4;  end
          3:       begin lg = 4'd3;  up = 16'h1234; mp = 4'd0;  end
          4:       begin lg = 4'd0;  up = 16'h5A5A; mp = 4'd7;  end
          5:       begin lg = 4'd15; up = 16'h8000; mp = 4'd15; end
          6:       begin lg = 4'd4;  up = 16'h0F0F; mp = 4'd1;  end
          7:       begin lg = 4'd8;  up = 16'hFFFF; mp = 4'd15; end
          8:       begin lg = 4'd5;  up = 16'h0000; mp = 4'd2;  end
          9:       begin lg = 4'd12; up = 16'h00FF; mp = 4'd9;  end
          default: begin
            lg = LOG2_W'($urandom_range(0, 15));
            up = ENT_W'($urandom);
            mp = PEN_W'($urandom_range(0, 15));
          end
        endcase
        write_reg(CFG_PATH_LOG2, ENT_W'(lg));
        write_reg(CFG_UPPER, up);
        write_reg(CFG_MAX_PEN, ENT_W'(mp));
        if (p == 1) begin
          send_beat(beat_of(REQ_FEEDBACK, 16'h0000, FB_TIMEOUT, 16'h0000));
          send_beat(beat_of(REQ_FEEDBACK, 16'hFFFF, FB_TIMEOUT, 16'hFFFF));
          send_beat(beat_of(REQ_NEXT, 16'h0000, FB_GOOD, 16'h0001));
          send_beat(beat_of(REQ_NEXT, 16'hFFFF, FB_TIMEOUT, 16'hFFFE));
        end
      end
      no_gaps = (p % 4 == 3);
      req_pct = $urandom_range(30, 70);
      for (int n = 0; n < BEATS_PER_PHASE; n++) send_beat(rand_beat(req_pct));
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pbps_pkg.sv
rtl/pbps_cfg.sv
rtl/penalty_bitmap_path_sprayer_top.sv
tb/sv/spray_checker.sv
tb/sv/penalty_bitmap_path_sprayer_top_tb.sv
